>>> hdl/ksm_pkg.sv
// ----------------------------------------------------------------------------
// ksm_pkg
// Shared constants, codes and types of the k-way sorted merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package ksm_pkg;

    localparam int NUM_LISTS  = 8;
    localparam int LIST_DEPTH = 64;

    localparam int LIST_W    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int PTR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W    = LIST_W + PTR_W;
    localparam int MEM_DEPTH = NUM_LISTS << PTR_W;

    localparam int VAL_W  = 32;
    localparam int IDX_W  = 3;
    localparam int SRC_W  = 3;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    localparam int IN_TDATA_W  = ((IDX_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VAL_W + SRC_W + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_POP    = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic              clr;
        logic              rd_valid;
        logic [LIST_W-1:0] list;
    } t_scan_ctl;

    typedef struct packed {
        logic                     found;
        logic [LIST_W-1:0]        list;
        logic signed [VAL_W-1:0]  value;
    } t_scan_res;

endpackage

`default_nettype wire

>>> hdl/ksm_ram.sv
// ----------------------------------------------------------------------------
// ksm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ksm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> hdl/ksm_min_scan.sv
// ----------------------------------------------------------------------------
// ksm_min_scan
// Running minimum over list heads as they return from the element RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module ksm_min_scan (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ksm_pkg::t_scan_ctl              i_ctl,
    input  wire logic [ksm_pkg::VAL_W-1:0]       i_rd_data,
    output ksm_pkg::t_scan_res                   o_res
);

    import ksm_pkg::*;

    logic                    r_found;
    logic [LIST_W-1:0]       r_best_list;
    logic signed [VAL_W-1:0] r_best_val;
    logic                    w_take;

    // strict less keeps the lowest list index on ties
    assign w_take = i_ctl.rd_valid && (!r_found || ($signed(i_rd_data) < r_best_val));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clr) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.clr && w_take) begin
            r_best_list <= i_ctl.list;
            r_best_val  <= $signed(i_rd_data);
        end
    end

    assign o_res.found = r_found;
    assign o_res.list  = r_best_list;
    assign o_res.value = r_best_val;

endmodule

`default_nettype wire

>>> hdl/k_way_sorted_merge.sv
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Eight fixed-depth FIFO lists in one RAM; append, pop-smallest, clear.
//
// Input channel s_*: one request per transaction. s_tuser carries the request
// code (append, pop, clear). s_tdata carries the list index and the value.
// Output channel m_*: exactly one result per request, in request order:
// popped value and source list in m_tdata, status code in m_tuser.
// Append, clear and the unused code go from accept straight to the emit state.
// Pop: scan, drain and finish states; one list head is read from the element
// RAM per cycle and compared in the cycle after against the running minimum.
// One request is in work at a time; s_tready is high only while idle.
// A finished result waits in the output register; a new request is taken
// meanwhile, and its own result waits until the output register frees up.
// Reset empties all lists; RAM contents are not cleared and no sweep runs.
// A stalled m_tready holds m_tvalid, m_tdata and m_tuser steady.
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_sorted_merge (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // [2:0] list_index, [34:3] element_value, [39:35] zero
    input  wire logic [ksm_pkg::IN_TDATA_W-1:0]       s_tdata,
    // [1:0] req_type
    input  wire logic [ksm_pkg::REQ_W-1:0]            s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [31:0] out_value, [34:32] source_list, [39:35] zero
    output logic      [ksm_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // [1:0] status
    output logic      [ksm_pkg::STAT_W-1:0]           m_tuser
);

    import ksm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_EMIT   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_rd_pos [NUM_LISTS];
    logic [CNT_W-1:0]   r_wr_cnt [NUM_LISTS];
    logic [LIST_W-1:0]  r_scan_idx;
    logic               r_rd_valid;
    logic [LIST_W-1:0]  r_rd_list;

    logic [VAL_W-1:0]   r_res_value;
    logic [SRC_W-1:0]   r_res_src;
    logic [STAT_W-1:0]  r_res_stat;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [STAT_W-1:0]      r_out_user;

    logic               w_accept;
    logic [REQ_W-1:0]   w_req;
    logic [IDX_W-1:0]   w_idx;
    logic [VAL_W-1:0]   w_val;
    logic [LIST_W-1:0]  w_list;
    logic               w_idx_bad;
    logic               w_full;
    logic               w_wr_en;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic               w_scan_ne;
    logic               w_rd_en;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [VAL_W-1:0]   w_rd_data;
    logic               w_scan_last;
    logic               w_emit;
    t_scan_ctl          w_ctl;
    t_scan_res          w_res;
    logic               w_cnt_zero;
    logic               w_ptr_ok;

    assign s_tready  = (r_state == ST_IDLE);
    assign w_accept  = s_tvalid && s_tready;
    assign w_req     = s_tuser;
    assign w_idx     = s_tdata[IDX_W-1:0];
    assign w_val     = s_tdata[IDX_W+VAL_W-1:IDX_W];
    assign w_list    = LIST_W'(w_idx);
    assign w_idx_bad = (32'(w_idx) >= 32'(NUM_LISTS));
    assign w_full    = (r_wr_cnt[w_list] >= CNT_W'(LIST_DEPTH));
    assign w_wr_en   = w_accept && (w_req == REQ_APPEND) && !w_idx_bad && !w_full;
    assign w_wr_addr = {w_list, r_wr_cnt[w_list][PTR_W-1:0]};

    assign w_scan_ne   = (r_rd_pos[r_scan_idx] < r_wr_cnt[r_scan_idx]);
    assign w_rd_en     = (r_state == ST_SCAN) && w_scan_ne;
    assign w_rd_addr   = {r_scan_idx, r_rd_pos[r_scan_idx][PTR_W-1:0]};
    assign w_scan_last = (r_scan_idx == LIST_W'(NUM_LISTS - 1));
    assign w_emit      = (r_state == ST_EMIT) && (!r_out_valid || m_tready);

    assign w_ctl.clr      = w_accept && (w_req == REQ_POP);
    assign w_ctl.rd_valid = r_rd_valid;
    assign w_ctl.list     = r_rd_list;

    ksm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MEM_DEPTH)
    ) u_elem_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_val),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    ksm_min_scan u_min_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_data (w_rd_data),
        .o_res     (w_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (w_req == REQ_POP) ? ST_SCAN : ST_EMIT;
                end
            end
            ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_FINISH;
            ST_FINISH: n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_rd_pos[i] <= '0;
                r_wr_cnt[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_rd_valid <= w_rd_en;
            if (w_wr_en) begin
                r_wr_cnt[w_list] <= r_wr_cnt[w_list] + CNT_W'(1);
            end
            if (w_accept && (w_req == REQ_CLEAR)) begin
                for (int i = 0; i < NUM_LISTS; i++) begin
                    r_rd_pos[i] <= '0;
                    r_wr_cnt[i] <= '0;
                end
            end
            if ((r_state == ST_FINISH) && w_res.found) begin
                r_rd_pos[w_res.list] <= r_rd_pos[w_res.list] + CNT_W'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_list <= r_scan_idx;
        if (w_accept) begin
            r_scan_idx <= '0;
        end else if (r_state == ST_SCAN) begin
            r_scan_idx <= r_scan_idx + LIST_W'(1);
        end
        if (w_accept) begin
            r_res_value <= '0;
            r_res_src   <= '0;
            r_res_stat  <= STAT_OK;
            if ((w_req == REQ_APPEND) && (w_idx_bad || w_full)) begin
                r_res_stat <= STAT_FULL;
            end
        end else if (r_state == ST_FINISH) begin
            if (w_res.found) begin
                r_res_value <= w_res.value;
                r_res_src   <= SRC_W'(w_res.list);
                r_res_stat  <= STAT_OK;
            end else begin
                r_res_value <= '0;
                r_res_src   <= '0;
                r_res_stat  <= STAT_EMPTY;
            end
        end
        if (w_emit) begin
            r_out_data <= OUT_TDATA_W'({r_res_src, r_res_value});
            r_out_user <= r_res_stat;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_user;

    always_comb begin
        w_cnt_zero = 1'b1;
        w_ptr_ok   = 1'b1;
        for (int i = 0; i < NUM_LISTS; i++) begin
            if ((r_wr_cnt[i] != '0) || (r_rd_pos[i] != '0)) begin
                w_cnt_zero = 1'b0;
            end
            if ((r_rd_pos[i] > r_wr_cnt[i]) || (r_wr_cnt[i] > CNT_W'(LIST_DEPTH))) begin
                w_ptr_ok = 1'b0;
            end
        end
    end

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tuser == STAT_EMPTY)) |-> (m_tdata == '0))
        else $error("empty pop result carries nonzero data");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_req == REQ_CLEAR)) |=> w_cnt_zero)
        else $error("clear left list pointers nonzero");

    a_ptr_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ptr_ok)
        else $error("read position passed write count or count exceeds depth");

    a_pop_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_req == REQ_POP)) |=> ((r_state == ST_SCAN) && !w_res.found))
        else $error("pop did not start a fresh scan");

endmodule

`default_nettype wire
